// ===== rtl/core/h264lp_pkg.sv =====
// shared types and constants of the length-prefix to start-code converter
`timescale 1ns / 1ps
package h264lp_pkg;

	localparam int PS_BYTES = 56;
	localparam int PS_AW    = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// status codes of a result word
	localparam logic [1:0] ST_DATA      = 2'd0;
	localparam logic [1:0] ST_PKT_ERR   = 2'd1;
	localparam logic [1:0] ST_EXTRA_OK  = 2'd2;
	localparam logic [1:0] ST_EXTRA_ERR = 2'd3;

	localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

	// sample stream phase
	typedef enum logic [1:0] {
		SP_LEN,
		SP_HEAD,
		SP_BODY,
		SP_DROP
	} sp_t;

	// extradata parser phase
	typedef enum logic [2:0] {
		EP_SKIP,
		EP_LSIZE,
		EP_SCOUNT,
		EP_ULHI,
		EP_ULLO,
		EP_UNIT,
		EP_PCOUNT,
		EP_TAIL
	} ep_t;

	// output sequencer phase
	typedef enum logic [1:0] {
		BK_PS,
		BK_SC,
		BK_ITEM
	} bk_t;

	// one job for the output sequencer: stored sets, start code, final word
	typedef struct packed {
		logic [PS_AW-1:0] ps_cnt;
		logic             start;
		logic             first;
		logic             has_item;
		logic [7:0]       data;
		logic [1:0]       status;
		logic             sps_missing;
		logic             pps_missing;
		logic [2:0]       lfb;
		logic             packet_end;
	} cmd_t;

endpackage

// ===== rtl/core/h264lp_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module h264lp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/h264lp_front.sv =====
// input parser: sample length framing, extradata parsing, job generation
`timescale 1ns / 1ps
module h264lp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        s_tuser,
	input  logic                        s_tlast,
	input  logic                        store_quiet,
	input  logic                        fifo_full,
	output logic                        push,
	output h264lp_pkg::cmd_t            push_cmd,
	output logic                        ram_we,
	output logic [h264lp_pkg::PS_AW-1:0] ram_waddr,
	output logic [7:0]                  ram_wdata
);
	import h264lp_pkg::*;

	sp_t              sp_q, sp_d;
	logic [23:0]      len_q, len_d;
	logic [1:0]       lbs_q, lbs_d;
	logic [30:0]      rem_q, rem_d;
	logic             first_q, first_d;
	logic [PS_AW-1:0] fill_q, fill_d;
	ep_t              ep_q, ep_d;
	logic [1:0]       eidx_q, eidx_d;
	logic [7:0]       units_q, units_d;
	logic [15:0]      ubl_q, ubl_d;
	logic             inpps_q, inpps_d;
	logic             sps_q, sps_d;
	logic             pps_q, pps_d;
	logic             eerr_q, eerr_d;
	logic [2:0]       lsize_q, lsize_d;
	logic [2:0]       pfx_cnt_q, pfx_cnt_d;
	logic [PS_AW-1:0] pfx_addr_q, pfx_addr_d;
	logic             accept;

	// prefix writes hold the input; extradata waits for the store to go quiet
	assign s_tready = !fifo_full && (pfx_cnt_q == 3'd0) && (!s_tuser || store_quiet);
	assign accept   = s_tvalid && s_tready;

	// next state and job generation
	always_comb begin
		logic [31:0] new_len;
		logic [16:0] need;
		logic        udone;
		cmd_t        c;
		sp_d       = sp_q;
		len_d      = len_q;
		lbs_d      = lbs_q;
		rem_d      = rem_q;
		first_d    = first_q;
		fill_d     = fill_q;
		ep_d       = ep_q;
		eidx_d     = eidx_q;
		units_d    = units_q;
		ubl_d      = ubl_q;
		inpps_d    = inpps_q;
		sps_d      = sps_q;
		pps_d      = pps_q;
		eerr_d     = eerr_q;
		lsize_d    = lsize_q;
		pfx_cnt_d  = pfx_cnt_q;
		pfx_addr_d = pfx_addr_q;
		push       = 1'b0;
		c          = '0;
		ram_we     = 1'b0;
		ram_waddr  = pfx_addr_q;
		ram_wdata  = 8'd0;
		new_len    = {len_q, s_tdata};
		need       = 17'd0;
		udone      = 1'b0;

		// pending start-code prefix of a stored unit
		if (pfx_cnt_q != 3'd0) begin
			ram_we     = 1'b1;
			ram_waddr  = pfx_addr_q;
			ram_wdata  = (pfx_cnt_q == 3'd1) ? 8'd1 : 8'd0;
			pfx_cnt_d  = pfx_cnt_q - 3'd1;
			pfx_addr_d = pfx_addr_q + PS_AW'(1);
		end

		if (accept && s_tuser) begin
			// extradata word
			if (ep_q == EP_SKIP && eidx_q == 2'd0) begin
				fill_d  = '0;
				sps_d   = 1'b0;
				pps_d   = 1'b0;
				inpps_d = 1'b0;
				eerr_d  = 1'b0;
			end
			if (!eerr_d) begin
				unique case (ep_q)
					EP_SKIP: begin
						if (eidx_q == 2'd3) begin
							eidx_d = 2'd0;
							ep_d   = EP_LSIZE;
						end else begin
							eidx_d = eidx_q + 2'd1;
						end
					end
					EP_LSIZE: begin
						lsize_d = {1'b0, s_tdata[1:0]} + 3'd1;
						ep_d    = EP_SCOUNT;
					end
					EP_SCOUNT: begin
						units_d = {3'd0, s_tdata[4:0]};
						if (s_tdata[4:0] != 5'd0) begin
							sps_d = 1'b1;
							ep_d  = EP_ULHI;
						end else begin
							inpps_d = 1'b1;
							ep_d    = EP_PCOUNT;
						end
					end
					EP_ULHI: begin
						ubl_d = {s_tdata, 8'd0};
						ep_d  = EP_ULLO;
					end
					EP_ULLO: begin
						ubl_d = {ubl_q[15:8], s_tdata};
						need  = 17'(fill_d) + 17'd4 + 17'(ubl_d);
						if (need > 17'(PS_BYTES)) begin
							eerr_d = 1'b1;
						end else begin
							pfx_cnt_d  = 3'd4;
							pfx_addr_d = fill_d;
							fill_d     = fill_d + PS_AW'(4);
							if (ubl_d == 16'd0) begin
								udone = 1'b1;
							end else begin
								ep_d = EP_UNIT;
							end
						end
					end
					EP_UNIT: begin
						ram_we    = 1'b1;
						ram_waddr = fill_d;
						ram_wdata = s_tdata;
						fill_d    = fill_d + PS_AW'(1);
						ubl_d     = ubl_q - 16'd1;
						if (ubl_d == 16'd0) begin
							udone = 1'b1;
						end
					end
					EP_PCOUNT: begin
						units_d = s_tdata;
						if (s_tdata != 8'd0) begin
							pps_d = 1'b1;
							ep_d  = EP_ULHI;
						end else begin
							ep_d = EP_TAIL;
						end
					end
					EP_TAIL: begin
						ep_d = EP_TAIL;
					end
					default: begin
						ep_d = EP_TAIL;
					end
				endcase
				// end of one stored unit
				if (udone) begin
					units_d = units_q - 8'd1;
					if (units_d != 8'd0) begin
						ep_d = EP_ULHI;
					end else if (!inpps_d) begin
						inpps_d = 1'b1;
						ep_d    = EP_PCOUNT;
					end else begin
						ep_d = EP_TAIL;
					end
				end
			end
			// record closes with one status word
			if (s_tlast) begin
				push       = 1'b1;
				c.has_item = 1'b1;
				if (!eerr_d && ep_d == EP_TAIL) begin
					c.status      = ST_EXTRA_OK;
					c.sps_missing = !sps_d;
					c.pps_missing = !pps_d;
					c.lfb         = lsize_d;
				end else begin
					c.status = ST_EXTRA_ERR;
					fill_d   = '0;
				end
				ep_d   = EP_SKIP;
				eidx_d = 2'd0;
				eerr_d = 1'b0;
			end
		end else if (accept) begin
			// sample word
			unique case (sp_q)
				SP_LEN: begin
					if (lbs_q != 2'd3) begin
						len_d = new_len[23:0];
						lbs_d = lbs_q + 2'd1;
						if (s_tlast) begin
							push       = 1'b1;
							c.has_item = 1'b1;
							c.status   = ST_PKT_ERR;
						end
					end else begin
						lbs_d = 2'd0;
						len_d = '0;
						rem_d = new_len[30:0];
						if (new_len[31]) begin
							push       = 1'b1;
							c.has_item = 1'b1;
							c.status   = ST_PKT_ERR;
							if (!s_tlast) begin
								sp_d = SP_DROP;
							end
						end else if (new_len == 32'd0) begin
							push    = 1'b1;
							c.start = 1'b1;
							c.first = first_q;
							first_d = 1'b0;
						end else if (s_tlast) begin
							push       = 1'b1;
							c.has_item = 1'b1;
							c.status   = ST_PKT_ERR;
						end else begin
							sp_d = SP_HEAD;
						end
					end
				end
				SP_HEAD, SP_BODY: begin
					push       = 1'b1;
					c.has_item = 1'b1;
					if (s_tlast && rem_q > 31'd1) begin
						c.status = ST_PKT_ERR;
					end else begin
						c.data = s_tdata;
						if (sp_q == SP_HEAD) begin
							c.start = 1'b1;
							c.first = first_q;
							first_d = 1'b0;
							if (s_tdata[4:0] == NAL_TYPE_IDR) begin
								c.ps_cnt = fill_q;
							end
						end
						rem_d = rem_q - 31'd1;
						sp_d  = (rem_d == 31'd0) ? SP_LEN : SP_BODY;
					end
				end
				SP_DROP: begin
					sp_d = SP_DROP;
				end
				default: begin
					sp_d = SP_LEN;
				end
			endcase
			// a packet error word always closes the packet, even before its last byte
			c.packet_end = s_tlast || (c.status == ST_PKT_ERR);
			// packet boundary restarts framing
			if (s_tlast) begin
				sp_d    = SP_LEN;
				len_d   = '0;
				lbs_d   = 2'd0;
				rem_d   = '0;
				first_d = 1'b1;
			end
		end
		push_cmd = c;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q       <= SP_LEN;
			len_q      <= '0;
			lbs_q      <= '0;
			rem_q      <= '0;
			first_q    <= 1'b1;
			fill_q     <= '0;
			ep_q       <= EP_SKIP;
			eidx_q     <= '0;
			units_q    <= '0;
			ubl_q      <= '0;
			inpps_q    <= 1'b0;
			sps_q      <= 1'b0;
			pps_q      <= 1'b0;
			eerr_q     <= 1'b0;
			lsize_q    <= 3'd4;
			pfx_cnt_q  <= '0;
			pfx_addr_q <= '0;
		end else begin
			sp_q       <= sp_d;
			len_q      <= len_d;
			lbs_q      <= lbs_d;
			rem_q      <= rem_d;
			first_q    <= first_d;
			fill_q     <= fill_d;
			ep_q       <= ep_d;
			eidx_q     <= eidx_d;
			units_q    <= units_d;
			ubl_q      <= ubl_d;
			inpps_q    <= inpps_d;
			sps_q      <= sps_d;
			pps_q      <= pps_d;
			eerr_q     <= eerr_d;
			lsize_q    <= lsize_d;
			pfx_cnt_q  <= pfx_cnt_d;
			pfx_addr_q <= pfx_addr_d;
		end
	end

	// store stays in bounds, prefix writing holds the input, and set insertion comes with a start code
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < PS_AW'(PS_BYTES)))
		else $error("store write out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pfx_cnt_q != 3'd0) |-> !s_tready)
		else $error("input taken during prefix write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cmd.ps_cnt != '0) |-> (push_cmd.start && !s_tuser))
		else $error("set insertion without start code");
endmodule

// ===== rtl/core/h264lp_cmd_fifo.sv =====
// short job queue between parser and output sequencer
`timescale 1ns / 1ps
module h264lp_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  h264lp_pkg::cmd_t push_cmd,
	input  logic             pop,
	output h264lp_pkg::cmd_t head,
	output logic             empty,
	output logic             full
);
	import h264lp_pkg::*;

	cmd_t               slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head  = slot_q[rptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/h264lp_back.sv =====
// output sequencer: stored sets, start code and final word of each job
`timescale 1ns / 1ps
module h264lp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  h264lp_pkg::cmd_t             cmd,
	input  logic                         cmd_valid,
	output logic                         pop,
	output logic                         busy,
	output logic                         ram_re,
	output logic [h264lp_pkg::PS_AW-1:0] ram_raddr,
	input  logic [7:0]                   ram_rdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata, // out_byte, sps_missing, pps_missing, length_field_bytes, run_last, zero pad
	output logic [1:0]                   m_tuser, // status
	output logic                         m_tlast  // packet_end
);
	import h264lp_pkg::*;

	cmd_t             cur_q;
	logic             busy_q, busy_d;
	bk_t              ph_q, ph_d;
	logic [PS_AW-1:0] idx_q, idx_d;
	logic             advance, cur_last, produce;

	logic             valid_s2, from_ps_s2, rl_s2, pe_s2, sm_s2, pm_s2;
	logic [7:0]       byte_s2, byte_o;
	logic [1:0]       st_s2, st_o;
	logic [2:0]       lfb_s2, lfb_o;
	logic             sm_o, pm_o, from_ps_o;

	assign advance = !valid_s2 || m_tready;
	assign produce = busy_q && advance;
	assign busy    = busy_q;

	// last word of the current job
	always_comb begin
		unique case (ph_q)
			BK_PS:   cur_last = (idx_q == cur_q.ps_cnt - PS_AW'(1)) && !cur_q.start
			                    && !cur_q.has_item;
			BK_SC:   cur_last = (idx_q == PS_AW'(3)) && !cur_q.has_item;
			BK_ITEM: cur_last = 1'b1;
			default: cur_last = 1'b1;
		endcase
	end

	assign pop = cmd_valid && (!busy_q || (produce && cur_last));

	// next state
	always_comb begin
		busy_d = busy_q;
		ph_d   = ph_q;
		idx_d  = idx_q;
		if (pop) begin
			busy_d = 1'b1;
			idx_d  = '0;
			if (cmd.ps_cnt != '0) begin
				ph_d = BK_PS;
			end else if (cmd.start) begin
				ph_d  = BK_SC;
				idx_d = cmd.first ? PS_AW'(0) : PS_AW'(1);
			end else begin
				ph_d = BK_ITEM;
			end
		end else if (produce && cur_last) begin
			busy_d = 1'b0;
		end else if (produce) begin
			unique case (ph_q)
				BK_PS: begin
					if (idx_q == cur_q.ps_cnt - PS_AW'(1)) begin
						if (cur_q.start) begin
							ph_d  = BK_SC;
							idx_d = cur_q.first ? PS_AW'(0) : PS_AW'(1);
						end else begin
							ph_d = BK_ITEM;
						end
					end else begin
						idx_d = idx_q + PS_AW'(1);
					end
				end
				BK_SC: begin
					if (idx_q == PS_AW'(3)) begin
						ph_d = BK_ITEM;
					end else begin
						idx_d = idx_q + PS_AW'(1);
					end
				end
				default: begin
					ph_d = BK_ITEM;
				end
			endcase
		end
	end

	// word built for the current phase
	always_comb begin
		byte_o    = 8'd0;
		st_o      = ST_DATA;
		sm_o      = 1'b0;
		pm_o      = 1'b0;
		lfb_o     = 3'd0;
		from_ps_o = 1'b0;
		ram_re    = produce && (ph_q == BK_PS);
		ram_raddr = idx_q;
		unique case (ph_q)
			BK_PS: begin
				from_ps_o = 1'b1;
			end
			BK_SC: begin
				byte_o = (idx_q == PS_AW'(3)) ? 8'd1 : 8'd0;
			end
			BK_ITEM: begin
				byte_o = cur_q.data;
				st_o   = cur_q.status;
				sm_o   = cur_q.sps_missing;
				pm_o   = cur_q.pps_missing;
				lfb_o  = cur_q.lfb;
			end
			default: begin
				byte_o = 8'd0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= BK_ITEM;
			idx_q  <= '0;
		end else begin
			busy_q <= busy_d;
			ph_q   <= ph_d;
			idx_q  <= idx_d;
		end
	end

	// current job
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= busy_q;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (produce) begin
			byte_s2    <= byte_o;
			from_ps_s2 <= from_ps_o;
			st_s2      <= st_o;
			sm_s2      <= sm_o;
			pm_s2      <= pm_o;
			lfb_s2     <= lfb_o;
			rl_s2      <= cur_last;
			pe_s2      <= cur_last && cur_q.packet_end;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, rl_s2, lfb_s2, pm_s2, sm_s2,
	                   from_ps_s2 ? ram_rdata : byte_s2};
	assign m_tuser  = st_s2;
	assign m_tlast  = pe_s2;

	// sequencing checks
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ph_q == BK_PS) |-> (idx_q < cur_q.ps_cnt))
		else $error("store read past job count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> (produce && cur_last))
		else $error("job replaced before finished");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> ($stable(byte_s2) && !$past(ram_re)))
		else $error("stalled word disturbed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[13])
		else $error("packet end without run end");
endmodule

// ===== rtl/core/h264_length_prefix_to_start_code.sv =====
// top level of the length-prefix to start-code converter
`timescale 1ns / 1ps
// Converts H.264 length-prefixed samples (s_tuser = 0) and their extradata
// record (s_tuser = 1) to start-code form, one byte per word in and out.
// Sample words are taken one per cycle while the four-entry job queue has
// room. Each input word yields zero or more output words, emitted one per
// cycle while m_tready is high; an IDR NAL header word yields up to the stored
// parameter-set bytes plus a start code plus itself, so once the job queue is
// full the input stalls while they are emitted. After the second length byte
// of each stored unit the input is held while the 00 00 00 01 prefix is written
// to the parameter-set memory, and extradata words are held off until the
// queue is empty and the sequencer idle, since the parameter-set memory is
// shared between record parsing and insertion.
module h264_length_prefix_to_start_code (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata, // data_byte
	input  logic        s_tuser, // command
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata, // out_byte, sps_missing, pps_missing, length_field_bytes, run_last, zero pad
	output logic [1:0]  m_tuser, // status
	output logic        m_tlast  // packet_end
);
	import h264lp_pkg::*;

	cmd_t             push_cmd, head;
	logic             push, pop, empty, full, busy, store_quiet;
	logic             ram_we, ram_re;
	logic [PS_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	assign store_quiet = empty && !busy;

	// parser
	h264lp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.store_quiet (store_quiet),
		.fifo_full   (full),
		.push        (push),
		.push_cmd    (push_cmd),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	// job queue
	h264lp_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// parameter-set store
	h264lp_ram #(
		.WIDTH (8),
		.DEPTH (PS_BYTES)
	) u_ps_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output sequencer
	h264lp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.cmd_valid (!empty),
		.pop       (pop),
		.busy      (busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);
endmodule

// ===== tb/h264_length_prefix_to_start_code_tb.sv =====
// self-checking testbench of the length-prefix to start-code converter
`timescale 1ns / 1ps
module h264_length_prefix_to_start_code_tb;
	import h264lp_pkg::*;

	// one expected output word
	typedef struct packed {
		logic       pend;
		logic       rl;
		logic [2:0] lfb;
		logic       pm;
		logic       sm;
		logic [1:0] st;
		logic [7:0] b;
	} annexb_word_t;

	// converter model and store of expected output words
	class annexb_scoreboard;
		logic [7:0]   ps_mem [PS_BYTES];
		sp_t          sph;
		logic [31:0]  len_acc, nal_left;
		int           len_seen;
		bit           first_nal;
		int           fill;
		ep_t          eph;
		int           hdr_idx;
		logic [7:0]   units;
		logic [15:0]  unit_left;
		bit           in_pps, sps_found, pps_found, rec_err;
		logic [2:0]   lsize;
		annexb_word_t pending_q[$];
		annexb_word_t cur[$];
		int           errors, words, ps_inserts, pkt_errs, rec_ok, rec_bad;

		function new();
			restart();
			fill = 0;
			eph = EP_SKIP;
			hdr_idx = 0;
			units = 0;
			unit_left = 0;
			in_pps = 0;
			sps_found = 0;
			pps_found = 0;
			rec_err = 0;
			lsize = 3'd4;
			errors = 0;
			words = 0;
			ps_inserts = 0;
			pkt_errs = 0;
			rec_ok = 0;
			rec_bad = 0;
		endfunction

		function void restart();
			sph = SP_LEN;
			len_acc = 0;
			len_seen = 0;
			nal_left = 0;
			first_nal = 1;
		endfunction

		function void put(logic [7:0] b, logic [1:0] st, bit sm, bit pm, logic [2:0] l);
			annexb_word_t w;
			w = '0;
			w.b = b;
			w.st = st;
			w.sm = sm;
			w.pm = pm;
			w.lfb = l;
			cur.push_back(w);
		endfunction

		function void start_code();
			if (first_nal)
				put(8'h00, ST_DATA, 0, 0, 3'd0);
			put(8'h00, ST_DATA, 0, 0, 3'd0);
			put(8'h00, ST_DATA, 0, 0, 3'd0);
			put(8'h01, ST_DATA, 0, 0, 3'd0);
			first_nal = 0;
		endfunction

		function void store(logic [7:0] b);
			if (fill < PS_BYTES) begin
				ps_mem[fill] = b;
				fill++;
			end
		endfunction

		function void unit_done();
			units = units - 8'd1;
			if (units != 0)
				eph = EP_ULHI;
			else if (!in_pps) begin
				in_pps = 1;
				eph = EP_PCOUNT;
			end else
				eph = EP_TAIL;
		endfunction

		// record parser, one byte
		function void record_byte(logic [7:0] b);
			if (eph == EP_SKIP && hdr_idx == 0) begin
				fill = 0;
				sps_found = 0;
				pps_found = 0;
				in_pps = 0;
				rec_err = 0;
			end
			if (rec_err)
				return;
			case (eph)
				EP_SKIP: begin
					if (hdr_idx >= 3) begin
						hdr_idx = 0;
						eph = EP_LSIZE;
					end else
						hdr_idx++;
				end
				EP_LSIZE: begin
					lsize = {1'b0, b[1:0]} + 3'd1;
					eph = EP_SCOUNT;
				end
				EP_SCOUNT: begin
					units = {3'b0, b[4:0]};
					if (units != 0) begin
						sps_found = 1;
						eph = EP_ULHI;
					end else begin
						in_pps = 1;
						eph = EP_PCOUNT;
					end
				end
				EP_ULHI: begin
					unit_left = {b, 8'h00};
					eph = EP_ULLO;
				end
				EP_ULLO: begin
					unit_left = unit_left | {8'h00, b};
					if (fill + 4 + int'(unit_left) > PS_BYTES)
						rec_err = 1;
					else begin
						store(8'h00);
						store(8'h00);
						store(8'h00);
						store(8'h01);
						if (unit_left == 0)
							unit_done();
						else
							eph = EP_UNIT;
					end
				end
				EP_UNIT: begin
					store(b);
					unit_left--;
					if (unit_left == 0)
						unit_done();
				end
				EP_PCOUNT: begin
					units = b;
					if (units != 0) begin
						pps_found = 1;
						eph = EP_ULHI;
					end else
						eph = EP_TAIL;
				end
				default: ;
			endcase
		endfunction

		// accepted input word: work out its output words
		function void note(bit cmd, logic [7:0] b, bit last);
			bit ends;
			ends = 0;
			cur.delete();
			if (cmd) begin
				record_byte(b);
				if (last) begin
					if (!rec_err && eph == EP_TAIL) begin
						put(8'h00, ST_EXTRA_OK, !sps_found, !pps_found, lsize);
						rec_ok++;
					end else begin
						fill = 0;
						put(8'h00, ST_EXTRA_ERR, 0, 0, 3'd0);
						rec_bad++;
					end
					eph = EP_SKIP;
					hdr_idx = 0;
					rec_err = 0;
				end
			end else begin
				case (sph)
					SP_LEN: begin
						len_acc = {len_acc[23:0], b};
						if (len_seen < 3) begin
							len_seen++;
							if (last) begin
								put(8'h00, ST_PKT_ERR, 0, 0, 3'd0);
								ends = 1;
							end
						end else begin
							len_seen = 0;
							nal_left = len_acc;
							len_acc = 0;
							if (nal_left[31]) begin
								put(8'h00, ST_PKT_ERR, 0, 0, 3'd0);
								ends = 1;
								if (!last)
									sph = SP_DROP;
							end else if (nal_left == 0) begin
								start_code();
								ends = last;
							end else if (last) begin
								put(8'h00, ST_PKT_ERR, 0, 0, 3'd0);
								ends = 1;
							end else
								sph = SP_HEAD;
						end
					end
					SP_HEAD, SP_BODY: begin
						if (last && nal_left > 1) begin
							put(8'h00, ST_PKT_ERR, 0, 0, 3'd0);
							ends = 1;
						end else begin
							if (sph == SP_HEAD) begin
								if (b[4:0] == NAL_TYPE_IDR) begin
									for (int i = 0; i < fill; i++)
										put(ps_mem[i], ST_DATA, 0, 0, 3'd0);
									ps_inserts++;
								end
								start_code();
							end
							put(b, ST_DATA, 0, 0, 3'd0);
							nal_left--;
							sph = (nal_left == 0) ? SP_LEN : SP_BODY;
							ends = last;
						end
					end
					default: ;
				endcase
				if (last)
					restart();
			end
			if (cur.size() > 0) begin
				cur[cur.size()-1].rl = 1;
				if (ends) begin
					cur[cur.size()-1].pend = 1;
					if (cur[cur.size()-1].st == ST_PKT_ERR)
						pkt_errs++;
				end
			end
			foreach (cur[i])
				pending_q.push_back(cur[i]);
		endfunction

		// accepted output word against the oldest expectation
		function void check(logic [15:0] d, logic [1:0] u, logic l);
			annexb_word_t e;
			logic [15:0] ed;
			words++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: actual data %h status %0d last %0b",
					$time, d, u, l);
				return;
			end
			e = pending_q.pop_front();
			ed = {2'b00, e.rl, e.lfb, e.pm, e.sm, e.b};
			if (ed !== d || e.st !== u || e.pend !== l) begin
				errors++;
				$display("%0t: mismatch: expected data %h status %0d last %0b,",
					$time, ed, e.st, e.pend);
				$display("    actual data %h status %0d last %0b", d, u, l);
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	annexb_scoreboard sb;
	bit          calm;
	bit          hold_req;
	int          in_words;
	int          idle_cycles;
	logic [7:0]  seq_q[$];

	h264_length_prefix_to_start_code uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitor both sides and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note(s_tuser, s_tdata, s_tlast);
				in_words <= in_words + 1;
			end
			if (m_tvalid && m_tready) begin
				sb.check(m_tdata, m_tuser, m_tlast);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 3000) begin
				$display("%0t: watchdog timeout, %0d words still expected", $time, sb.pending());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// output side: random stalls and one long hold-off
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// send one word, with an occasional idle burst in front
	task automatic send_word(bit cmd, logic [7:0] b, bit last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// send the built sequence, last on its final word
	task automatic send_seq(bit cmd);
		foreach (seq_q[i])
			send_word(cmd, seq_q[i], i == seq_q.size() - 1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic add_unit(int n);
		seq_q.push_back(n[15:8]);
		seq_q.push_back(n[7:0]);
		repeat (n) seq_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// build an extradata record
	task automatic build_record(int nsps, int npps, int ulen, int tail);
		seq_q.delete();
		repeat (4) seq_q.push_back(8'($urandom_range(0, 255)));
		seq_q.push_back(8'($urandom_range(0, 255)));
		seq_q.push_back({3'($urandom_range(0, 7)), 5'(nsps)});
		repeat (nsps) add_unit(ulen < 0 ? int'($urandom_range(0, 6)) : ulen);
		seq_q.push_back(8'(npps));
		repeat (npps) add_unit(ulen < 0 ? int'($urandom_range(0, 6)) : ulen);
		repeat (tail) seq_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// append one NAL with a 4-byte length and a chosen header byte
	task automatic add_nal(int n, logic [7:0] hdr);
		seq_q.push_back(n[31:24]);
		seq_q.push_back(n[23:16]);
		seq_q.push_back(n[15:8]);
		seq_q.push_back(n[7:0]);
		if (n > 0) seq_q.push_back(hdr);
		for (int i = 1; i < n; i++) seq_q.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] rand_hdr();
		if ($urandom_range(0, 2) == 0)
			return {3'($urandom_range(0, 7)), NAL_TYPE_IDR};
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_packet();
		int k;
		seq_q.delete();
		repeat ($urandom_range(1, 3)) begin
			k = int'($urandom_range(0, 19));
			if (k == 0)
				add_nal(0, 8'h00);
			else if (k == 1) begin
				// negative length, rest dropped
				seq_q.push_back({1'b1, 7'($urandom_range(0, 127))});
				repeat ($urandom_range(3, 6)) seq_q.push_back(8'($urandom_range(0, 255)));
			end else if (k == 2) begin
				// huge positive length, ends truncated
				seq_q.push_back(8'($urandom_range(0, 127)));
				repeat ($urandom_range(3, 6)) seq_q.push_back(8'($urandom_range(0, 255)));
			end else
				add_nal(int'($urandom_range(1, 8)), rand_hdr());
		end
		if ($urandom_range(0, 9) == 0)
			seq_q = seq_q[0:$urandom_range(0, seq_q.size() - 1)];
		send_seq(1'b0);
	endtask

	task automatic random_record();
		int u;
		u = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 60)) : -1;
		build_record(int'($urandom_range(0, 2)), int'($urandom_range(0, 2)), u,
			int'($urandom_range(0, 2)));
		if ($urandom_range(0, 7) == 0)
			seq_q = seq_q[0:$urandom_range(0, seq_q.size() - 1)];
		send_seq(1'b1);
	endtask

	initial begin
		sb = new();
		calm = 0;
		hold_req = 0;
		in_words = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: good record, IDR with sets, later NALs, zero length
		build_record(1, 1, 2, 1);
		send_seq(1'b1);
		seq_q.delete();
		add_nal(2, 8'h65);
		add_nal(1, 8'hff);
		add_nal(0, 8'h00);
		send_seq(1'b0);
		// negative length, short length, truncated NAL
		seq_q = '{8'h80, 8'h00, 8'h00, 8'h01, 8'hff};
		send_seq(1'b0);
		seq_q = '{8'h00, 8'h00};
		send_seq(1'b0);
		seq_q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h25, 8'h00};
		send_seq(1'b0);
		// record with no sets, overflowing record, truncated record
		build_record(0, 0, 0, 0);
		send_seq(1'b1);
		build_record(1, 0, 60, 0);
		send_seq(1'b1);
		build_record(1, 1, 1, 0);
		seq_q = seq_q[0:6];
		send_seq(1'b1);
		// sender waits for every result
		drain();

		// random part; long receiver hold-off near the start
		hold_req = 1;
		while (in_words < 300) begin
			if (in_words > 250) calm = 1;
			case ($urandom_range(0, 9))
				0, 1: random_record();
				2: send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				default: random_packet();
			endcase
		end

		drain();
		repeat (80) @(posedge clk);
		$display("%0d words in, %0d words out, %0d set insertions, %0d packet errors",
			in_words, sb.words, sb.ps_inserts, sb.pkt_errs);
		$display("extradata records: %0d loaded, %0d rejected", sb.rec_ok, sb.rec_bad);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
